@@ src/atm_pkg.sv @@
// Shared types and codes of the alarm table matcher.
`timescale 1ns / 1ps

package atm_pkg;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_DEL     = 3'd1;
  localparam logic [2:0] MODE_CLEAR   = 3'd2;
  localparam logic [2:0] MODE_CHECK   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_MISSING   = 2'd2;

  localparam logic [1:0] REP_ONCE     = 2'd0;
  localparam logic [1:0] REP_DAILY    = 2'd1;
  localparam logic [1:0] REP_WEEKLY   = 2'd2;

  localparam int unsigned CNT_OUT_W   = 5;

  typedef struct packed {
    logic [15:0] id;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [1:0]  rep;
  } entry_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [1:0]  rep;
    logic [15:0] target_id;
    logic [3:0]  index;
  } req_t;

  typedef enum logic [1:0] {
    RD_TOP   = 2'd0,
    RD_INDEX = 2'd1,
    RD_DOWN  = 2'd2,
    RD_UP    = 2'd3
  } rd_sel_t;

  typedef enum logic {
    WR_APPEND = 1'b0,
    WR_SHIFT  = 1'b1
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef enum logic [2:0] {
    RK_NONE = 3'd0,
    RK_NEW  = 3'd1,
    RK_HIT  = 3'd2,
    RK_GONE = 3'd3,
    RK_FULL = 3'd4,
    RK_MISS = 3'd5
  } res_kind_t;

  typedef struct packed {
    logic      load_req;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    cnt_op_t   cnt_op;
    logic      id_inc;
    logic      res_en;
    res_kind_t res_kind;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       idx_ok;
    logic       hit;
    logic       at_bottom;
    logic       more_above;
    logic       out_free;
  } ctl_sts_t;

endpackage

@@ src/atm_ctrl.sv @@
// Controller state machine of the alarm table matcher.
`timescale 1ns / 1ps

module atm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  atm_pkg::ctl_sts_t  sts,
  output atm_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FETCH = 6'b001000,
    S_SHIFT = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (sts.mode)
          atm_pkg::MODE_ADD: begin
            cmd.res_en = 1'b1;
            if (sts.full) begin
              cmd.res_kind = atm_pkg::RK_FULL;
            end else begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = atm_pkg::WR_APPEND;
              cmd.cnt_op   = atm_pkg::CNT_INC;
              cmd.id_inc   = 1'b1;
              cmd.res_kind = atm_pkg::RK_NEW;
            end
          end
          atm_pkg::MODE_DEL, atm_pkg::MODE_CHECK: begin
            if (sts.empty) begin
              cmd.res_en   = 1'b1;
              cmd.res_kind = (sts.mode == atm_pkg::MODE_DEL) ? atm_pkg::RK_MISS
                                                              : atm_pkg::RK_NONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = atm_pkg::RD_TOP;
              state_nxt  = S_SCAN;
            end
          end
          atm_pkg::MODE_CLEAR: begin
            cmd.cnt_op   = atm_pkg::CNT_CLR;
            cmd.res_en   = 1'b1;
            cmd.res_kind = atm_pkg::RK_NONE;
          end
          atm_pkg::MODE_READ: begin
            if (sts.idx_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = atm_pkg::RD_INDEX;
              state_nxt  = S_FETCH;
            end else begin
              cmd.res_en   = 1'b1;
              cmd.res_kind = atm_pkg::RK_MISS;
            end
          end
          default: begin
            cmd.res_en   = 1'b1;
            cmd.res_kind = atm_pkg::RK_MISS;
          end
        endcase
      end
      S_FETCH: begin
        cmd.res_en   = 1'b1;
        cmd.res_kind = atm_pkg::RK_HIT;
        state_nxt    = S_RESP;
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.res_en = 1'b1;
          if (sts.mode == atm_pkg::MODE_DEL) begin
            cmd.res_kind = atm_pkg::RK_GONE;
            if (sts.more_above) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = atm_pkg::RD_UP;
              state_nxt  = S_SHIFT;
            end else begin
              cmd.cnt_op = atm_pkg::CNT_DEC;
              state_nxt  = S_RESP;
            end
          end else begin
            cmd.res_kind = atm_pkg::RK_HIT;
            state_nxt    = S_RESP;
          end
        end else if (sts.at_bottom) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = (sts.mode == atm_pkg::MODE_DEL) ? atm_pkg::RK_MISS
                                                          : atm_pkg::RK_NONE;
          state_nxt    = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = atm_pkg::RD_DOWN;
        end
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = atm_pkg::WR_SHIFT;
        if (sts.more_above) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = atm_pkg::RD_UP;
        end else begin
          cmd.cnt_op = atm_pkg::CNT_DEC;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/atm_datapath.sv @@
// Datapath of the alarm table matcher: request latch, entry memory, counters, result.
`timescale 1ns / 1ps

module atm_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  atm_pkg::req_t                      req,
  input  atm_pkg::ctl_cmd_t                  cmd,
  output atm_pkg::ctl_sts_t                  sts,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic                               out_matched,
  output atm_pkg::entry_t                    out_entry,
  output logic [atm_pkg::CNT_OUT_W-1:0]      out_count
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (CW > 4) ? CW : 4;

  atm_pkg::req_t   req_r;
  atm_pkg::entry_t mem [TABLE_DEPTH];
  atm_pkg::entry_t rdata_r;
  logic [AW-1:0]   rd_addr_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  atm_pkg::entry_t wr_data;
  atm_pkg::entry_t new_entry;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [15:0]     id_r;
  logic [1:0]      res_status_r;
  logic            res_matched_r;
  atm_pkg::entry_t res_entry_r;
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic            out_matched_r;
  atm_pkg::entry_t out_entry_r;
  logic [atm_pkg::CNT_OUT_W-1:0] out_count_r;
  logic            hm;
  logic            slot_match;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req;
    end
  end

  always_comb begin
    new_entry.id     = id_r + 16'd1;
    new_entry.year   = req_r.year;
    new_entry.month  = req_r.month;
    new_entry.day    = req_r.day;
    new_entry.wday   = req_r.wday;
    new_entry.hour   = req_r.hour;
    new_entry.minute = req_r.minute;
    new_entry.rep    = req_r.rep;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      atm_pkg::RD_TOP:   rd_addr = AW'(count_r - CW'(1));
      atm_pkg::RD_INDEX: rd_addr = AW'(IW'(count_r) - IW'(req_r.index) - IW'(1));
      atm_pkg::RD_DOWN:  rd_addr = rd_addr_r - AW'(1);
      atm_pkg::RD_UP:    rd_addr = rd_addr_r + AW'(1);
      default:           rd_addr = rd_addr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      atm_pkg::WR_APPEND: begin
        wr_addr = AW'(count_r);
        wr_data = new_entry;
      end
      atm_pkg::WR_SHIFT: begin
        wr_addr = rd_addr_r - AW'(1);
        wr_data = rdata_r;
      end
      default: begin
        wr_addr = rd_addr_r;
        wr_data = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_comb begin
    unique case (cmd.cnt_op)
      atm_pkg::CNT_HOLD: count_nxt = count_r;
      atm_pkg::CNT_INC:  count_nxt = count_r + CW'(1);
      atm_pkg::CNT_DEC:  count_nxt = count_r - CW'(1);
      atm_pkg::CNT_CLR:  count_nxt = '0;
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      id_r    <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.id_inc) begin
        id_r <= id_r + 16'd1;
      end
    end
  end

  always_comb begin
    hm = (rdata_r.hour == req_r.hour) && (rdata_r.minute == req_r.minute);
    unique case (rdata_r.rep)
      atm_pkg::REP_ONCE:   slot_match = hm && (rdata_r.year == req_r.year)
                                        && (rdata_r.month == req_r.month)
                                        && (rdata_r.day == req_r.day);
      atm_pkg::REP_DAILY:  slot_match = hm;
      atm_pkg::REP_WEEKLY: slot_match = hm && (rdata_r.wday == req_r.wday);
      default:             slot_match = 1'b0;
    endcase
  end

  always_comb begin
    sts.mode       = req_r.mode;
    sts.full       = (count_r == CW'(TABLE_DEPTH));
    sts.empty      = (count_r == '0);
    sts.idx_ok     = (IW'(req_r.index) < IW'(count_r));
    sts.hit        = (req_r.mode == atm_pkg::MODE_DEL) ? (rdata_r.id == req_r.target_id)
                                                       : slot_match;
    sts.at_bottom  = (rd_addr_r == '0);
    sts.more_above = ((CW'(rd_addr_r) + CW'(1)) < count_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      unique case (cmd.res_kind)
        atm_pkg::RK_NEW: begin
          res_status_r  <= atm_pkg::ST_OK;
          res_matched_r <= 1'b0;
          res_entry_r   <= new_entry;
        end
        atm_pkg::RK_HIT: begin
          res_status_r  <= atm_pkg::ST_OK;
          res_matched_r <= 1'b1;
          res_entry_r   <= rdata_r;
        end
        atm_pkg::RK_GONE: begin
          res_status_r  <= atm_pkg::ST_OK;
          res_matched_r <= 1'b0;
          res_entry_r   <= rdata_r;
        end
        atm_pkg::RK_FULL: begin
          res_status_r  <= atm_pkg::ST_FULL;
          res_matched_r <= 1'b0;
          res_entry_r   <= '0;
        end
        atm_pkg::RK_MISS: begin
          res_status_r  <= atm_pkg::ST_MISSING;
          res_matched_r <= 1'b0;
          res_entry_r   <= '0;
        end
        default: begin
          res_status_r  <= atm_pkg::ST_OK;
          res_matched_r <= 1'b0;
          res_entry_r   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r  <= res_status_r;
      out_matched_r <= res_matched_r;
      out_entry_r   <= res_entry_r;
      out_count_r   <= atm_pkg::CNT_OUT_W'(count_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_matched = out_matched_r;
  assign out_entry   = out_entry_r;
  assign out_count   = out_count_r;

endmodule

@@ src/alarm_table_matcher.sv @@
// Top level of the alarm table matcher.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   mode, date, time, repeat kind, id, index
//   out_     output     out_valid / out_stall status, matched, entry fields, count
//
// Add, delete all and unknown modes read no entry: the result is registered, then moved
// to the output register. Check walks the entry memory one entry per cycle through its
// registered read port, newest entry first; read fetches only the entry at its index.
// Delete by id scans, then compacts one entry per cycle.
// Reset empties the table and clears the id counter; memory contents are not cleared.
// in_stall is high while a request is at work; a stalled result holds in the
// output register, and the next result waits for it to be taken.
`timescale 1ns / 1ps

module alarm_table_matcher #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [2:0]  in_weekday,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [1:0]  in_repeat_kind,
  input  logic [15:0] in_target_id,
  input  logic [3:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_matched,
  output logic [15:0] out_entry_id,
  output logic [11:0] out_entry_year,
  output logic [3:0]  out_entry_month,
  output logic [4:0]  out_entry_day,
  output logic [2:0]  out_entry_weekday,
  output logic [4:0]  out_entry_hour,
  output logic [5:0]  out_entry_minute,
  output logic [1:0]  out_entry_repeat,
  output logic [4:0]  out_entry_count
);

  atm_pkg::req_t     req;
  atm_pkg::ctl_cmd_t cmd;
  atm_pkg::ctl_sts_t sts;
  atm_pkg::entry_t   out_entry;

  always_comb begin
    req.mode      = in_mode;
    req.year      = in_year;
    req.month     = in_month;
    req.day       = in_day;
    req.wday      = in_weekday;
    req.hour      = in_hour;
    req.minute    = in_minute;
    req.rep       = in_repeat_kind;
    req.target_id = in_target_id;
    req.index     = in_entry_index;
  end

  atm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  atm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_matched (out_matched),
    .out_entry   (out_entry),
    .out_count   (out_entry_count)
  );

  assign out_entry_id      = out_entry.id;
  assign out_entry_year    = out_entry.year;
  assign out_entry_month   = out_entry.month;
  assign out_entry_day     = out_entry.day;
  assign out_entry_weekday = out_entry.wday;
  assign out_entry_hour    = out_entry.hour;
  assign out_entry_minute  = out_entry.minute;
  assign out_entry_repeat  = out_entry.rep;

endmodule
